// ----- sv/rcuf_pkg.sv -----
// ============================================================================
// rcuf_pkg: shared constants for the row/column union-find block
// Field widths, counter widths and epoch tag codes used by all files.
// ============================================================================
package rcuf_pkg;

  localparam int COORD_W = 10;  // row / column field width
  localparam int CNT_W   = 11;  // point and component counters
  localparam int EPOCH_W = 4;   // table entry tag width

  localparam logic [CNT_W-1:0]   POINT_CAP   = 11'h7FF;
  localparam logic [EPOCH_W-1:0] EPOCH_CLEAR = 4'h0;  // never a live epoch
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 4'h1;
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 4'hF;

endpackage

// ----- sv/rcuf_if.sv -----
// ============================================================================
// rcuf_if: request and result channels
// Valid/ready channels carrying one grid point and one component report.
// ============================================================================
interface rcuf_in_if import rcuf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               new_set;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;

  modport source (output valid, output new_set, output row, output col, input ready);
  modport sink   (input valid, input new_set, input row, input col, output ready);
endinterface

interface rcuf_out_if import rcuf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] removable;
  logic [CNT_W-1:0] components;
  logic             overflow;

  modport source (output valid, output removable, output components, output overflow,
                  input ready);
  modport sink   (input valid, input removable, input components, input overflow,
                  output ready);
endinterface

// ----- sv/rcuf_table.sv -----
// ============================================================================
// rcuf_table: coordinate-to-group table
// One write port, one registered read port; an entry is live when its tag
// matches the current epoch.
// ============================================================================
module rcuf_table import rcuf_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int GW    = 10
) (
  input  logic               clk,
  input  logic [AW-1:0]      rd_addr,
  input  logic [EPOCH_W-1:0] cur_tag,
  output logic               hit,
  output logic [GW-1:0]      grp,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [EPOCH_W-1:0] wr_tag,
  input  logic [GW-1:0]      wr_grp
);

  logic [EPOCH_W+GW-1:0] mem [DEPTH];
  logic [EPOCH_W+GW-1:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_tag, wr_grp};
    end
    rd_q_r <= mem[rd_addr];
  end

  assign hit = (rd_q_r[EPOCH_W+GW-1 -: EPOCH_W] == cur_tag);
  assign grp = rd_q_r[GW-1:0];

endmodule

// ----- sv/row_col_union_find_components.sv -----
// ============================================================================
// row_col_union_find_components: connected components of grid points
// Groups points sharing a row or column through row/column tables and a
// union-find parent memory without path compression.
// ============================================================================
//  channel   dir  handshake     payload
//  in_ch     in   valid/ready   new_set, row, col
//  out_ch    out  valid/ready   removable, components, overflow
//
//  Per point the sequencer reduces, looks up both tables, walks both parent
//  chains when both tables hit different groups, and loads the output, where a
//  reduction is one subtract of COORD_RANGE from an out-of-range coordinate.
//  The parent memory read port sets the walk rate: one link per cycle.
//  After reset, and on every 15th new_set, the row/column tags are swept:
//  every entry is cleared to EPOCH_CLEAR while in_ready is low.
//  A waiting result does not block the next request; it only holds the
//  output stage if still untaken when the next result is ready.
module row_col_union_find_components import rcuf_pkg::*; #(
  parameter int COORD_RANGE = 1024,
  parameter int MAX_GROUPS  = 1024
) (
  input logic         clk,
  input logic         rst_n,
  rcuf_in_if.sink     in_ch,
  rcuf_out_if.source  out_ch
);

  localparam int CW  = $clog2(COORD_RANGE);
  localparam int GW  = $clog2(MAX_GROUPS);
  localparam int GMW = GW + 1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_REDUCE, S_LOOK, S_FIND_A, S_FIND_B, S_OUT
  } state_t;

  state_t             state_r;
  logic               pend_r;
  logic [CW-1:0]      clr_idx_r;
  logic [EPOCH_W-1:0] epoch_r;
  logic [COORD_W-1:0] row_r, col_r;
  logic [GMW-1:0]     groups_r;
  logic [CNT_W-1:0]   points_r, comps_r;
  logic               drop_r;
  logic [GW-1:0]      a_r, b_r;

  logic               out_valid_r;
  logic [CNT_W-1:0]   out_removable_r, out_components_r;
  logic               out_overflow_r;

  // table ports
  logic               row_hit, col_hit;
  logic [GW-1:0]      row_grp, col_grp;
  logic               row_we, col_we;
  logic [CW-1:0]      row_waddr, col_waddr;
  logic [EPOCH_W-1:0] tbl_wtag;
  logic [GW-1:0]      row_wgrp, col_wgrp;

  // parent memory
  logic [GW-1:0]      par_mem [MAX_GROUPS];
  logic [GW-1:0]      par_q_r;
  logic [GW-1:0]      par_raddr;
  logic               par_we;
  logic [GW-1:0]      par_waddr, par_wdata;

  // shared units
  logic               row_big, col_big;
  logic [COORD_W-1:0] red_diff;
  logic [GW-1:0]      walk_cur;
  logic               walk_hit;
  logic               need_new, grp_full, pt_full;
  logic [GW-1:0]      new_g;
  logic [CNT_W-1:0]   points_nxt;

  assign row_big  = (32'(row_r) >= COORD_RANGE);
  assign col_big  = (32'(col_r) >= COORD_RANGE);
  assign red_diff = (row_big ? row_r : col_r) - COORD_W'(COORD_RANGE);

  assign walk_cur = (state_r == S_FIND_A) ? a_r : b_r;
  assign walk_hit = (par_q_r == walk_cur);

  assign need_new   = !row_hit && !col_hit;
  assign grp_full   = (groups_r >= GMW'(MAX_GROUPS));
  assign pt_full    = (points_r >= POINT_CAP);
  assign new_g      = groups_r[GW-1:0];
  assign points_nxt = points_r + (drop_r ? CNT_W'(0) : CNT_W'(1));

  rcuf_table #(.DEPTH(COORD_RANGE), .AW(CW), .GW(GW)) u_row_tbl (
    .clk     (clk),
    .rd_addr (CW'(row_r)),
    .cur_tag (epoch_r),
    .hit     (row_hit),
    .grp     (row_grp),
    .wr_en   (row_we),
    .wr_addr (row_waddr),
    .wr_tag  (tbl_wtag),
    .wr_grp  (row_wgrp)
  );

  rcuf_table #(.DEPTH(COORD_RANGE), .AW(CW), .GW(GW)) u_col_tbl (
    .clk     (clk),
    .rd_addr (CW'(col_r)),
    .cur_tag (epoch_r),
    .hit     (col_hit),
    .grp     (col_grp),
    .wr_en   (col_we),
    .wr_addr (col_waddr),
    .wr_tag  (tbl_wtag),
    .wr_grp  (col_wgrp)
  );

  // table and parent write / read steering
  always_comb begin
    row_we    = 1'b0;
    col_we    = 1'b0;
    row_waddr = CW'(row_r);
    col_waddr = CW'(col_r);
    tbl_wtag  = epoch_r;
    row_wgrp  = new_g;
    col_wgrp  = new_g;
    par_we    = 1'b0;
    par_waddr = new_g;
    par_wdata = new_g;
    par_raddr = row_grp;
    unique case (state_r)
      S_CLEAR: begin
        row_we    = 1'b1;
        col_we    = 1'b1;
        row_waddr = clr_idx_r;
        col_waddr = clr_idx_r;
        tbl_wtag  = EPOCH_CLEAR;
        row_wgrp  = '0;
        col_wgrp  = '0;
      end
      S_LOOK: begin
        if (!pt_full) begin
          if (need_new) begin
            if (!grp_full) begin
              row_we = 1'b1;
              col_we = 1'b1;
              par_we = 1'b1;
            end
          end else if (!row_hit) begin
            row_we   = 1'b1;
            row_wgrp = col_grp;
          end else if (!col_hit) begin
            col_we   = 1'b1;
            col_wgrp = row_grp;
          end
        end
      end
      S_FIND_A: begin
        par_raddr = walk_hit ? b_r : par_q_r;
      end
      S_FIND_B: begin
        par_raddr = par_q_r;
        if (walk_hit && (a_r != b_r)) begin
          par_we    = 1'b1;
          par_waddr = b_r;
          par_wdata = a_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (par_we) begin
      par_mem[par_waddr] <= par_wdata;
    end
    par_q_r <= par_mem[par_raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      pend_r      <= 1'b0;
      clr_idx_r   <= '0;
      epoch_r     <= EPOCH_FIRST;
      groups_r    <= '0;
      points_r    <= '0;
      comps_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // in S_OUT a taken result is replaced by the load below
      if (out_valid_r && out_ch.ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          if (clr_idx_r == CW'(COORD_RANGE - 1)) begin
            clr_idx_r <= '0;
            pend_r    <= 1'b0;
            state_r   <= pend_r ? S_REDUCE : S_IDLE;
          end else begin
            clr_idx_r <= clr_idx_r + CW'(1);
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            row_r <= in_ch.row;
            col_r <= in_ch.col;
            if (in_ch.new_set) begin
              groups_r <= '0;
              points_r <= '0;
              comps_r  <= '0;
              // tags would wrap onto stale entries: sweep instead
              if (epoch_r == EPOCH_LAST) begin
                epoch_r <= EPOCH_FIRST;
                pend_r  <= 1'b1;
                state_r <= S_CLEAR;
              end else begin
                epoch_r <= epoch_r + EPOCH_W'(1);
                state_r <= S_REDUCE;
              end
            end else begin
              state_r <= S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          if (row_big) begin
            row_r <= red_diff;
          end else if (col_big) begin
            col_r <= red_diff;
          end else begin
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          drop_r <= pt_full || (need_new && grp_full);
          if (!pt_full && need_new && !grp_full) begin
            groups_r <= groups_r + GMW'(1);
            comps_r  <= comps_r + CNT_W'(1);
          end
          if (!pt_full && row_hit && col_hit && (row_grp != col_grp)) begin
            a_r     <= row_grp;
            b_r     <= col_grp;
            state_r <= S_FIND_A;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_FIND_A: begin
          if (walk_hit) begin
            state_r <= S_FIND_B;
          end else begin
            a_r <= par_q_r;
          end
        end
        S_FIND_B: begin
          if (walk_hit) begin
            if ((a_r != b_r) && (comps_r != '0)) begin
              comps_r <= comps_r - CNT_W'(1);
            end
            state_r <= S_OUT;
          end else begin
            b_r <= par_q_r;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            points_r         <= points_nxt;
            out_valid_r      <= 1'b1;
            out_removable_r  <= points_nxt - comps_r;
            out_components_r <= comps_r;
            out_overflow_r   <= drop_r;
            state_r          <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.removable  = out_removable_r;
  assign out_ch.components = out_components_r;
  assign out_ch.overflow   = out_overflow_r;

endmodule

// ----- sv/rcuf_checker.sv -----
// ============================================================================
// rcuf_checker: port-level checks for the union-find block
// Watches the request and result channels of the top level.
// ============================================================================
module rcuf_checker import rcuf_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [CNT_W-1:0] out_removable,
  input logic [CNT_W-1:0] out_components,
  input logic             out_overflow
);

  // reset starts the tag sweep, so no request is taken right after it
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("request ready right after reset");

  // one point at a time
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready again right after a request");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_removable)
      && $stable(out_components) && $stable(out_overflow))
    else $error("stalled result changed");

  // a kept point always leaves at least one group
  a_kept_has_group: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_overflow |-> out_components != '0)
    else $error("kept point with zero components");

endmodule

bind row_col_union_find_components rcuf_checker u_rcuf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_removable  (out_ch.removable),
  .out_components (out_ch.components),
  .out_overflow   (out_ch.overflow)
);

// ----- tb/tb_row_col_union_find_components.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_row_col_union_find_components: self-checking bench for the grid-point
// union-find block
// Streams grid points through the request channel, runs a union-find model
// of its own alongside, and checks every component report in order. A
// directed table comes first, then random sets, parent chains and noise
// under several idle and stall mixes.
// ============================================================================
module tb_row_col_union_find_components;
  import rcuf_pkg::*;

  localparam int GRID_N  = 1024;  // rows and columns per axis
  localparam int MAX_GRP = 1024;  // group table depth

  typedef struct packed {
    logic [CNT_W-1:0] removable;
    logic [CNT_W-1:0] components;
    logic             overflow;
  } report_t;

  typedef struct packed {
    bit               ns;
    bit [COORD_W-1:0] row;
    bit [COORD_W-1:0] col;
    bit               typed;   // 1: rep below is the expected report
    report_t          rep;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  rcuf_in_if  in_if ();
  rcuf_out_if out_if ();

  row_col_union_find_components DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Union-find model of the grid
  // --------------------------------------------------------------------------
  bit               row_used [GRID_N];
  bit [COORD_W-1:0] row_grp  [GRID_N];
  bit               col_used [GRID_N];
  bit [COORD_W-1:0] col_grp  [GRID_N];
  bit [COORD_W-1:0] grp_parent [MAX_GRP];
  bit [CNT_W-1:0]   grp_made;
  bit [CNT_W-1:0]   pt_total;
  bit [CNT_W-1:0]   comp_total;

  report_t expected_reports [$];
  report_t want;

  int idle_pct  = 0;  // sender idle chance per cycle
  int stall_pct = 0;  // receiver stall chance per cycle
  int n_points  = 0;
  int n_sets    = 0;
  int n_dropped = 0;
  int n_checked = 0;
  int n_errors  = 0;
  int phase_start;

  function automatic void grid_clear();
    for (int i = 0; i < GRID_N; i++) begin
      row_used[i] = 1'b0;
      row_grp[i]  = '0;
      col_used[i] = 1'b0;
      col_grp[i]  = '0;
    end
    for (int i = 0; i < MAX_GRP; i++) grp_parent[i] = '0;
    grp_made   = '0;
    pt_total   = '0;
    comp_total = '0;
  endfunction

  function automatic bit [COORD_W-1:0] grid_root(input bit [COORD_W-1:0] g);
    int steps;
    steps = 0;
    while (grp_parent[g] != g && steps < MAX_GRP) begin
      g = grp_parent[g];
      steps++;
    end
    return g;
  endfunction

  function automatic report_t grid_place(input bit ns, input bit [COORD_W-1:0] r,
                                         input bit [COORD_W-1:0] c);
    report_t          rep;
    bit               drop;
    bit [COORD_W-1:0] g;
    bit [COORD_W-1:0] jr;
    bit [COORD_W-1:0] kr;
    drop = 1'b0;
    if (ns) begin
      grid_clear();
      n_sets++;
    end
    if (pt_total >= POINT_CAP) begin
      drop = 1'b1;
    end else if (!row_used[r] && !col_used[c]) begin
      if (grp_made >= MAX_GRP) begin
        drop = 1'b1;
      end else begin
        g = grp_made[COORD_W-1:0];
        grp_parent[g] = g;
        row_grp[r]  = g;
        row_used[r] = 1'b1;
        col_grp[c]  = g;
        col_used[c] = 1'b1;
        grp_made++;
        comp_total++;
      end
    end else if (!row_used[r]) begin
      row_grp[r]  = col_grp[c];
      row_used[r] = 1'b1;
    end else if (!col_used[c]) begin
      col_grp[c]  = row_grp[r];
      col_used[c] = 1'b1;
    end else if (row_grp[r] != col_grp[c]) begin
      jr = grid_root(row_grp[r]);
      kr = grid_root(col_grp[c]);
      if (jr != kr) begin
        grp_parent[kr] = jr;  // column root goes under row root
        if (comp_total != 0) comp_total--;
      end
    end
    if (drop) n_dropped++;
    else      pt_total++;
    rep.removable  = pt_total - comp_total;
    rep.components = comp_total;
    rep.overflow   = drop;
    return rep;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  task automatic push_point(input bit ns, input bit [COORD_W-1:0] r,
                            input bit [COORD_W-1:0] c, input bit use_typed,
                            input report_t typed_rep);
    report_t rep;
    in_if.valid   <= 1'b1;
    in_if.new_set <= ns;
    in_if.row     <= r;
    in_if.col     <= c;
    do @(posedge clk); while (!in_if.ready);
    rep = grid_place(ns, r, c);
    if (use_typed) rep = typed_rep;
    expected_reports = {expected_reports, rep};
    n_points++;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic pt(input bit ns, input int r, input int c);
    push_point(ns, r[COORD_W-1:0], c[COORD_W-1:0], 1'b0, '0);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  // Clustered points in a small window so rows and columns collide often.
  task automatic window_set();
    int len, w, rb, cb;
    bit ns;
    ns  = ($urandom_range(9) < 7);
    len = $urandom_range(1, 40);
    w   = $urandom_range(1, 15);
    rb  = $urandom_range(0, GRID_N - 1 - w);
    cb  = $urandom_range(0, GRID_N - 1 - w);
    for (int i = 0; i < len; i++)
      pt(i == 0 ? ns : 1'b0, rb + $urandom_range(0, w), cb + $urandom_range(0, w));
  endtask

  // Diagonal groups linked one under the next: builds a parent chain of
  // depth k, then two points that walk the whole chain.
  task automatic chain_set(input int k);
    int b;
    b = $urandom_range(0, GRID_N - 2 - k);
    pt(1'b1, b, b);
    for (int i = 1; i <= k; i++) pt(1'b0, b + i, b + i);
    for (int i = 0; i < k; i++) pt(1'b0, b + i + 1, b + i);
    pt(1'b0, b + k, b);
    pt(1'b0, b, b + k);
  endtask

  task automatic noise_run();
    int len;
    len = $urandom_range(1, 20);
    for (int i = 0; i < len; i++)
      pt($urandom_range(19) == 0, $urandom_range(GRID_N - 1), $urandom_range(GRID_N - 1));
  endtask

  task automatic random_phase(input int snd_idle, input int rcv_stall, input int count);
    int pick;
    wait_drained();
    idle_pct    = snd_idle;
    stall_pct   = rcv_stall;
    phase_start = n_points;
    while (n_points - phase_start < count) begin
      pick = $urandom_range(9);
      if (pick < 6)      window_set();
      else if (pick < 8) chain_set($urandom_range(2, 30));
      else               noise_run();
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected result removable=%0d components=%0d overflow=%0b",
                 $time, out_if.removable, out_if.components, out_if.overflow);
        n_errors++;
      end else begin
        want = expected_reports.pop_front();
        n_checked++;
        if (out_if.removable !== want.removable) begin
          $display("%0t: removable expected %0d actual %0d",
                   $time, want.removable, out_if.removable);
          n_errors++;
        end
        if (out_if.components !== want.components) begin
          $display("%0t: components expected %0d actual %0d",
                   $time, want.components, out_if.components);
          n_errors++;
        end
        if (out_if.overflow !== want.overflow) begin
          $display("%0t: overflow expected %0b actual %0b",
                   $time, want.overflow, out_if.overflow);
          n_errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  dir_row_t directed_tbl [16];

  initial begin
    directed_tbl = '{
      '{1'b1, 10'd0,    10'd0,    1'b1, '{11'd0, 11'd1, 1'b0}},  // first point
      '{1'b0, 10'd1023, 10'd1023, 1'b1, '{11'd0, 11'd2, 1'b0}},  // far corner
      '{1'b0, 10'd0,    10'd1023, 1'b1, '{11'd2, 11'd1, 1'b0}},  // joins both
      '{1'b0, 10'd0,    10'd0,    1'b1, '{11'd3, 11'd1, 1'b0}},  // repeat
      '{1'b0, 10'd5,    10'd0,    1'b0, '0},                     // new row
      '{1'b0, 10'd1023, 10'd7,    1'b0, '0},                     // new column
      '{1'b0, 10'd512,  10'd512,  1'b0, '0},
      '{1'b0, 10'd341,  10'd682,  1'b0, '0},
      '{1'b0, 10'd682,  10'd341,  1'b0, '0},
      '{1'b0, 10'd341,  10'd341,  1'b0, '0},                     // merge
      '{1'b0, 10'd682,  10'd682,  1'b0, '0},                     // same root
      '{1'b0, 10'd512,  10'd0,    1'b0, '0},
      '{1'b1, 10'd1023, 10'd0,    1'b1, '{11'd0, 11'd1, 1'b0}},  // clear
      '{1'b0, 10'd0,    10'd1023, 1'b1, '{11'd0, 11'd2, 1'b0}},
      '{1'b0, 10'd1023, 10'd1023, 1'b1, '{11'd2, 11'd1, 1'b0}},
      '{1'b0, 10'd0,    10'd0,    1'b0, '0}
    };
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.new_set = 1'b0;
    in_if.row     = '0;
    in_if.col     = '0;
    grid_clear();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_tbl[i])
      push_point(directed_tbl[i].ns, directed_tbl[i].row, directed_tbl[i].col,
                 directed_tbl[i].typed, directed_tbl[i].rep);

    // one deep parent chain, then the mixed random phases
    wait_drained();
    chain_set(100);
    random_phase(0, 0, 210);
    random_phase(88, 0, 210);
    random_phase(0, 88, 210);
    random_phase(28, 28, 210);

    wait_drained();
    repeat (2100) @(posedge clk);

    $display("Covered %0d points in %0d sets, %0d of them dropped at capacity;",
             n_points, n_sets, n_dropped);
    $display("%0d reports checked, %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0 && expected_reports.size() == 0) begin
      $display("row_col_union_find_components verification clean");
    end else begin
      $display("row_col_union_find_components verification failed");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("row_col_union_find_components verification failed");
    $finish;
  end

endmodule

// ----- row_col_union_find_components.f -----
sv/rcuf_pkg.sv
sv/rcuf_if.sv
sv/rcuf_table.sv
sv/row_col_union_find_components.sv
sv/rcuf_checker.sv
tb/tb_row_col_union_find_components.sv
